// ===== hdl/vector3_alu_macros.svh =====
// vector3_alu_macros.svh: assertion macros shared by the vector3_alu rtl
// no dependencies; every user must have i_clk and i_rst_n in scope
`ifndef VECTOR3_ALU_MACROS_SVH
`define VECTOR3_ALU_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define V3A_ASSERT_NOW(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("vector3_alu check failed");
// next-cycle implication, checked outside reset
`define V3A_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("vector3_alu check failed");
`else
`define V3A_ASSERT_NOW(name, cond, prop)
`define V3A_ASSERT_NEXT(name, cond, prop)
`endif
`endif

// ===== hdl/v3a_pkg.sv =====
// v3a_pkg: shared types, command codes and saturation helper for vector3_alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package v3a_pkg;

    // command codes
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_SCALE = 3'd2;
    localparam logic [2:0] CMD_DOT   = 3'd3;
    localparam logic [2:0] CMD_CROSS = 3'd4;
    localparam logic [2:0] CMD_DIST  = 3'd5;
    localparam logic [2:0] CMD_NORM  = 3'd6;

    // clamp values
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // datapath widths
    localparam int unsigned PROD_W     = 66;
    localparam int unsigned WIDE_W     = 68;
    localparam int unsigned SQRT_STEPS = 32;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic signed [31:0] result_scalar;
        logic               saturated;
        logic               zero_length;
    } t_out;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sat_val;

    // per-lane result handed to the merge stage
    typedef struct packed {
        logic [31:0] val;
        logic        sat;
        logic [31:0] mag;
        logic        neg;
    } t_lane_res;

    // clamp a wide signed value to 32 bits
    function automatic t_sat_val settle(input logic signed [WIDE_W-1:0] v);
        t_sat_val r;
        if ((v[WIDE_W-1:31] == '0) || (v[WIDE_W-1:31] == '1)) begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end else if (v[WIDE_W-1]) begin
            r.val = SAT_NEG;
            r.sat = 1'b1;
        end else begin
            r.val = SAT_POS;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/v3a_lane.sv =====
// v3a_lane: one component lane: add/sub, two multipliers, shift and clamp
// depends on v3a_pkg
`timescale 1ns / 1ps
`default_nettype none

module v3a_lane #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [2:0]                           i_cmd,
    input  logic signed [31:0]                   i_a,
    input  logic signed [31:0]                   i_b,
    input  logic signed [31:0]                   i_s,
    input  logic signed [31:0]                   i_aj,
    input  logic signed [31:0]                   i_bk,
    input  logic signed [31:0]                   i_ak,
    input  logic signed [31:0]                   i_bj,
    output logic signed [v3a_pkg::PROD_W-1:0]    o_prod,
    output v3a_pkg::t_lane_res                   o_res
);

    localparam int unsigned WW = v3a_pkg::WIDE_W;

    logic signed [32:0] a_ext, b_ext, n_sum, n_diff, n_m1, n_m2;
    logic [31:0]        n_mag;

    logic [2:0]         r_cmd_a, r_cmd_b;
    logic signed [32:0] r_sum_a, r_sum_b, r_m1, r_m2;
    logic signed [31:0] r_m3, r_m4;
    logic [31:0]        r_mag_a, r_mag_b;
    logic               r_neg_a, r_neg_b;
    logic signed [v3a_pkg::PROD_W-1:0] r_p;
    logic signed [63:0] r_q;

    logic signed [WW-1:0] w_sum, w_p, w_q, w_diff, w_sel;
    v3a_pkg::t_sat_val    sv;
    v3a_pkg::t_lane_res   r_res;

    // operand selection
    always_comb begin
        a_ext  = 33'(i_a);
        b_ext  = 33'(i_b);
        n_diff = a_ext - b_ext;
        n_sum  = (i_cmd == v3a_pkg::CMD_SUB) ? n_diff : (a_ext + b_ext);
        n_mag  = i_a[31] ? 32'(-a_ext) : i_a;
        unique case (i_cmd)
            v3a_pkg::CMD_SCALE: begin
                n_m1 = 33'(i_s);
                n_m2 = a_ext;
            end
            v3a_pkg::CMD_CROSS: begin
                n_m1 = 33'(i_aj);
                n_m2 = 33'(i_bk);
            end
            v3a_pkg::CMD_DIST: begin
                n_m1 = n_diff;
                n_m2 = n_diff;
            end
            v3a_pkg::CMD_NORM: begin
                n_m1 = a_ext;
                n_m2 = a_ext;
            end
            default: begin
                n_m1 = a_ext;
                n_m2 = b_ext;
            end
        endcase
    end

    // operand and product stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd_a <= i_cmd;
            r_sum_a <= n_sum;
            r_m1    <= n_m1;
            r_m2    <= n_m2;
            r_m3    <= i_ak;
            r_m4    <= i_bj;
            r_mag_a <= n_mag;
            r_neg_a <= i_a[31];
            r_cmd_b <= r_cmd_a;
            r_sum_b <= r_sum_a;
            r_p     <= r_m1 * r_m2;
            r_q     <= r_m3 * r_m4;
            r_mag_b <= r_mag_a;
            r_neg_b <= r_neg_a;
        end
    end

    // shift and clamp
    always_comb begin
        w_sum  = WW'(r_sum_b);
        w_p    = WW'(r_p);
        w_q    = WW'(r_q);
        w_diff = w_p - w_q;
        unique case (r_cmd_b)
            v3a_pkg::CMD_SCALE: w_sel = w_p >>> FRAC_BITS;
            v3a_pkg::CMD_CROSS: w_sel = w_diff >>> FRAC_BITS;
            default:            w_sel = w_sum;
        endcase
        sv = v3a_pkg::settle(w_sel);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.val <= sv.val;
            r_res.sat <= sv.sat;
            r_res.mag <= r_mag_b;
            r_res.neg <= r_neg_b;
        end
    end

    assign o_prod = r_p;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== hdl/v3a_sqrt.sv =====
// v3a_sqrt: pipelined floor square root, one result bit per stage
// depends on v3a_pkg
`timescale 1ns / 1ps
`default_nettype none

module v3a_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    localparam int unsigned N = v3a_pkg::SQRT_STEPS;

    logic [63:0] r_rem  [N-1];
    logic [31:0] r_root [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam int unsigned BIT = N - 1 - s;
        logic [63:0] rem_in;
        logic [31:0] root_in;
        logic [65:0] trial, diff;
        logic        fit;

        if (s == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        // try setting this bit: rem >= 2*root*2^bit + 2^(2*bit)
        assign trial = (66'(root_in) << (BIT + 1)) | (66'(1) << (2 * BIT));
        assign diff  = 66'(rem_in) - trial;
        assign fit   = !diff[65];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[s] <= fit ? (root_in | (32'(1) << BIT)) : root_in;
            end
        end

        if (s < N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= fit ? diff[63:0] : rem_in;
                end
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

`default_nettype wire

// ===== hdl/v3a_div.sv =====
// v3a_div: pipelined restoring divider, (mag << FRAC_BITS) / den
// quotient is known to stay within FRAC_BITS+1 bits; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module v3a_div #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_mag,
    input  logic [31:0]          i_den,
    output logic [FRAC_BITS:0]   o_quot
);

    localparam int unsigned STEPS = FRAC_BITS + 1;
    localparam int unsigned DW    = 32 + FRAC_BITS;

    logic [DW-1:0]    r_rem [STEPS-1];
    logic [31:0]      r_den [STEPS-1];
    logic [STEPS-1:0] r_q   [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        localparam int unsigned BIT = STEPS - 1 - s;
        logic [DW-1:0]    rem_in;
        logic [31:0]      den_in;
        logic [STEPS-1:0] q_in;
        logic [DW:0]      diff;
        logic             fit;

        if (s == 0) begin : g_first
            assign rem_in = {i_mag, {FRAC_BITS{1'b0}}};
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
        end

        // subtract the shifted divisor when it fits
        assign diff = {1'b0, rem_in} - ((DW + 1)'(den_in) << BIT);
        assign fit  = !diff[DW];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s] <= fit ? (q_in | (STEPS'(1) << BIT)) : q_in;
            end
        end

        if (s < STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= fit ? diff[DW-1:0] : rem_in;
                    r_den[s] <= den_in;
                end
            end
        end
    end

    assign o_quot = r_q[STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/vector3_alu.sv =====
// vector3_alu: three lanes, dot/radicand merge, square root and divide pipes
// datapath: a beat passes the lanes and merge, then the 32-stage root pipe
// and FRAC_BITS+1 divide stages before it reaches the output register
// throughput: one beat per cycle while o_in_stall is low; a two-entry output stage absorbs a stall
// reset: synchronous active-low i_rst_n clears all valid flags, no beat in flight
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_alu_macros.svh"

module vector3_alu #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  v3a_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output v3a_pkg::t_out   o_out_data
);

    localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
    localparam int unsigned DLY       = v3a_pkg::SQRT_STEPS + DIV_STEPS;
    localparam int unsigned SQ_TAP    = v3a_pkg::SQRT_STEPS - 1;
    localparam int unsigned VLD_N     = 3 + DLY;
    localparam int unsigned WW        = v3a_pkg::WIDE_W;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [2:0][31:0] vec;
        logic             vec_sat;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [31:0]      scal;
        logic             scal_sat;
        logic             dist_big;
    } t_hold;

    logic en, acc, out_free, pipe_fire;
    logic [VLD_N-1:0] r_vld;

    logic signed [31:0] a_v [3];
    logic signed [31:0] b_v [3];
    logic signed [v3a_pkg::PROD_W-1:0] prod [3];
    v3a_pkg::t_lane_res lres [3];
    logic [FRAC_BITS:0] quot [3];
    logic [31:0]        nq   [3];

    logic [2:0]  r_cmd_a, r_cmd_b, r_cmd_c;
    logic [31:0] r_scal_c;
    logic        r_scal_sat_c, r_big_c;
    logic [63:0] r_rad;
    logic signed [WW-1:0] w_sum, w_dot;
    v3a_pkg::t_sat_val    dot_sv;

    t_hold       n_hold0;
    t_hold       r_hold [DLY];
    t_hold       h;
    logic [31:0] root;
    logic [31:0] r_root [DIV_STEPS];
    logic [31:0] rt;

    logic [2:0][31:0] vo;
    logic [31:0]      so;
    logic             sat_o, zero_o;
    v3a_pkg::t_out    n_res, r_out, r_skid;
    logic             r_out_valid, r_skid_valid;

    // handshake: the whole pipe moves unless the spare output entry is taken
    assign en        = !r_skid_valid;
    assign acc       = i_in_valid && en;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pipe_fire = en && r_vld[VLD_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[VLD_N-2:0], acc};
        end
    end

    // lane inputs
    assign a_v[0] = i_in_data.a_x;
    assign a_v[1] = i_in_data.a_y;
    assign a_v[2] = i_in_data.a_z;
    assign b_v[0] = i_in_data.b_x;
    assign b_v[1] = i_in_data.b_y;
    assign b_v[2] = i_in_data.b_z;

    // per-component lanes and dividers
    for (genvar l = 0; l < 3; l++) begin : g_lane
        localparam int unsigned J = (l + 1) % 3;
        localparam int unsigned K = (l + 2) % 3;

        v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cmd  (i_in_data.command),
            .i_a    (a_v[l]),
            .i_b    (b_v[l]),
            .i_s    (i_in_data.scale),
            .i_aj   (a_v[J]),
            .i_bk   (b_v[K]),
            .i_ak   (a_v[K]),
            .i_bj   (b_v[J]),
            .o_prod (prod[l]),
            .o_res  (lres[l])
        );

        v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_mag  (r_hold[SQ_TAP].mag[l]),
            .i_den  (root),
            .o_quot (quot[l])
        );

        assign nq[l] = 32'(quot[l]);
    end

    // merge: sum of the three lane products for dot and radicand
    always_comb begin
        w_sum  = WW'(prod[0]) + WW'(prod[1]) + WW'(prod[2]);
        w_dot  = w_sum >>> FRAC_BITS;
        dot_sv = v3a_pkg::settle(w_dot);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd_a      <= i_in_data.command;
            r_cmd_b      <= r_cmd_a;
            r_cmd_c      <= r_cmd_b;
            r_scal_c     <= dot_sv.val;
            r_scal_sat_c <= dot_sv.sat;
            r_big_c      <= |w_sum[WW-1:62];
            r_rad        <= w_sum[63:0];
        end
    end

    // collect lane results for the hold line
    always_comb begin
        n_hold0.cmd      = r_cmd_c;
        n_hold0.vec      = {lres[2].val, lres[1].val, lres[0].val};
        n_hold0.vec_sat  = lres[0].sat | lres[1].sat | lres[2].sat;
        n_hold0.mag      = {lres[2].mag, lres[1].mag, lres[0].mag};
        n_hold0.neg      = {lres[2].neg, lres[1].neg, lres[0].neg};
        n_hold0.scal     = r_scal_c;
        n_hold0.scal_sat = r_scal_sat_c;
        n_hold0.dist_big = r_big_c;
    end

    v3a_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (root)
    );

    // hold line alongside the root and divide pipes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hold[0] <= n_hold0;
            for (int k = 1; k < DLY; k++) begin
                r_hold[k] <= r_hold[k-1];
            end
            r_root[0] <= root;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_root[k] <= r_root[k-1];
            end
        end
    end

    assign h  = r_hold[DLY-1];
    assign rt = r_root[DIV_STEPS-1];

    // final result select
    always_comb begin
        vo     = '0;
        so     = '0;
        sat_o  = 1'b0;
        zero_o = 1'b0;
        unique case (h.cmd)
            v3a_pkg::CMD_ADD, v3a_pkg::CMD_SUB, v3a_pkg::CMD_SCALE,
            v3a_pkg::CMD_CROSS: begin
                vo    = h.vec;
                sat_o = h.vec_sat;
            end
            v3a_pkg::CMD_DOT: begin
                so    = h.scal;
                sat_o = h.scal_sat;
            end
            v3a_pkg::CMD_DIST: begin
                if (h.dist_big) begin
                    so    = v3a_pkg::SAT_POS;
                    sat_o = 1'b1;
                end else begin
                    so = {1'b0, rt[30:0]};
                end
            end
            v3a_pkg::CMD_NORM: begin
                if (rt == '0) begin
                    zero_o = 1'b1;
                end else begin
                    for (int l = 0; l < 3; l++) begin
                        vo[l] = h.neg[l] ? (32'(0) - nq[l]) : nq[l];
                    end
                end
            end
            default: begin
            end
        endcase
        n_res.result_x      = vo[0];
        n_res.result_y      = vo[1];
        n_res.result_z      = vo[2];
        n_res.result_scalar = so;
        n_res.saturated     = sat_o;
        n_res.zero_length   = zero_o;
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= pipe_fire;
            end
        end else if (pipe_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (!out_free && pipe_fire) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `V3A_ASSERT_NOW(a_skid_needs_out, r_skid_valid, r_out_valid)
    `V3A_ASSERT_NEXT(a_skid_holds, r_skid_valid && i_out_stall, r_skid_valid)
    `V3A_ASSERT_NEXT(a_fire_reaches_out, pipe_fire, r_out_valid)
    `V3A_ASSERT_NOW(a_zero_clean, o_out_valid && o_out_data.zero_length, o_out_data.result_x == 0 && o_out_data.result_y == 0 && o_out_data.result_z == 0 && o_out_data.result_scalar == 0 && !o_out_data.saturated)

endmodule

`default_nettype wire
